FILE: src/twc_pkg.sv
package twc_pkg;

	// Fixed-point layout of the walk term and the correction.
	localparam int FRAC_BITS   = 24;                      // Q0.24 inverse square root
	localparam int QUO_BITS    = 2 * FRAC_BITS + 3;       // floor(2^50 / q), up to 2^50
	localparam int ROOT_BITS   = (QUO_BITS + 1) / 2;      // isqrt of the quotient
	localparam int REM_BITS    = ROOT_BITS + 2;           // square-root partial remainder
	localparam int INV_BITS    = FRAC_BITS + 1;           // rounded 1/sqrt(q), at most 2^24
	localparam int W_BITS      = INV_BITS + 2;            // signed sum of four terms
	localparam int COEF_BITS   = 32;                      // signed Q16.16 coefficient
	localparam int PROD_BITS   = COEF_BITS + W_BITS;      // signed Q19.40 product
	localparam int ROUND_SHIFT = 16 + FRAC_BITS;          // product LSB weight 2^-40
	localparam int CORR_BITS   = PROD_BITS - ROUND_SHIFT; // rounded correction in ps
	localparam int LANES       = 4;                       // charges per event

	// Output sideband bit positions.
	localparam int USER_INVALID = 0;
	localparam int USER_SAT     = 1;

endpackage

FILE: src/time_walk_correction.sv
// Time-walk correction for coincidence events.
// Input channel s_axis: one beat per event, carrying the signed time difference and
// the four unsigned charges. Output channel m_axis: one beat per event, carrying the
// corrected time, with the invalid-charge and saturation flags in tuser.
// cfg: a write of the signed Q16.16 walk coefficient; it is taken at any time and is
// meant to change only while no event is in flight.
// Each charge goes through a radix-2 divider computing floor(2^50/q), one quotient bit
// per stage, then a digit-by-digit square root, one root bit per stage. Then come a
// stage that sums the four rounded inverse roots, a stage that multiplies by the
// coefficient and a stage that rounds, subtracts and clamps into the output register.
// Throughput is one event per cycle; the divider and square-root stages set the depth.
// When the receiver stalls while a result waits, the whole pipeline holds. Nothing is
// lost or repeated, and s_axis_tready drops until the output beat is taken.
// Reset clears the valid bits of all stages and sets the coefficient to zero.
// An event with any zero charge passes its time through unchanged, with the invalid
// flag set and the saturation flag clear.
module time_walk_correction
	import twc_pkg::*;
#(
	parameter int CHARGE_BITS = 16,
	parameter int TIME_BITS   = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// time_difference, charge_first_a, charge_first_b, charge_second_a, charge_second_b
	input  logic [((TIME_BITS + 4 * CHARGE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// corrected_time
	output logic [((TIME_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
	// charge_invalid, saturated
	output logic [1:0]                    m_axis_tuser,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [COEF_BITS-1:0]          cfg_data
);

	localparam int OUT_W     = ((TIME_BITS + 7) / 8) * 8;
	localparam int SUM_STG   = QUO_BITS + ROOT_BITS;
	localparam int MUL_STG   = SUM_STG + 1;
	localparam int OUT_STG   = SUM_STG + 2;
	localparam int STAGES    = OUT_STG + 1;
	localparam int DIFF_BITS = ((TIME_BITS > CORR_BITS) ? TIME_BITS : CORR_BITS) + 1;
	localparam logic signed [DIFF_BITS-1:0] T_MAX = DIFF_BITS'((64'd1 << (TIME_BITS - 1)) - 64'd1);
	localparam logic signed [DIFF_BITS-1:0] T_MIN = -T_MAX - DIFF_BITS'(1);

	logic                          adv;
	logic [COEF_BITS-1:0]          coef_q;
	logic [TIME_BITS-1:0]          time_in;
	logic [CHARGE_BITS-1:0]        chg_in [LANES];
	logic                          inv_in;

	// Event bookkeeping carried beside the arithmetic of every stage.
	logic                          vld_s [STAGES];
	logic [TIME_BITS-1:0]          tim_s [OUT_STG];
	logic                          inv_s [OUT_STG];

	// Divider and square-root lanes.
	logic [CHARGE_BITS-1:0]        dv_rem_s [LANES][QUO_BITS];
	logic [CHARGE_BITS-1:0]        dv_div_s [LANES][QUO_BITS];
	logic [QUO_BITS-1:0]           dv_quo_s [LANES][QUO_BITS];
	logic [2*ROOT_BITS-1:0]        sq_rad_s [LANES][ROOT_BITS];
	logic [REM_BITS-1:0]           sq_rem_s [LANES][ROOT_BITS];
	logic [ROOT_BITS-1:0]          sq_root_s [LANES][ROOT_BITS];

	logic signed [W_BITS-1:0]      w_s;
	logic signed [PROD_BITS-1:0]   prod_s;
	logic [TIME_BITS-1:0]          res_s;
	logic                          res_inv_s;
	logic                          res_sat_s;

	// The whole pipeline moves unless a finished result is held by the receiver.
	assign adv           = !vld_s[OUT_STG] || m_axis_tready;
	assign s_axis_tready = adv;
	assign cfg_ready     = 1'b1;

	// Coefficient register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg_valid) begin
			coef_q <= cfg_data;
		end
	end

	// Unpack the input beat.
	always_comb begin
		time_in = s_axis_tdata[TIME_BITS-1:0];
		inv_in  = 1'b0;
		for (int j = 0; j < LANES; j++) begin
			chg_in[j] = s_axis_tdata[TIME_BITS + j * CHARGE_BITS +: CHARGE_BITS];
			if (chg_in[j] == '0) begin
				inv_in = 1'b1;
			end
		end
	end

	// Valid bits of all stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < STAGES; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[0] <= s_axis_tvalid;
			for (int k = 1; k < STAGES; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// Time and invalid flag ride along until the output stage.
	always_ff @(posedge clk) begin
		if (adv) begin
			tim_s[0] <= time_in;
			inv_s[0] <= inv_in;
			for (int k = 1; k < OUT_STG; k++) begin
				tim_s[k] <= tim_s[k-1];
				inv_s[k] <= inv_s[k-1];
			end
		end
	end

	for (genvar j = 0; j < LANES; j++) begin : g_lane
		// Restoring division of 2^50 by the charge, one quotient bit per stage.
		for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
			logic [CHARGE_BITS-1:0] rem_prev;
			logic [CHARGE_BITS-1:0] div_prev;
			logic [QUO_BITS-1:0]    quo_prev;
			logic [CHARGE_BITS:0]   trial;
			logic [CHARGE_BITS:0]   diff;

			if (k == 0) begin : g_first
				assign rem_prev = '0;
				assign div_prev = chg_in[j];
				assign quo_prev = '0;
				// The dividend has its only set bit at the top quotient position.
				assign trial    = {rem_prev, 1'b1};
			end else begin : g_next
				assign rem_prev = dv_rem_s[j][k-1];
				assign div_prev = dv_div_s[j][k-1];
				assign quo_prev = dv_quo_s[j][k-1];
				assign trial    = {rem_prev, 1'b0};
			end

			assign diff = trial - {1'b0, div_prev};

			always_ff @(posedge clk) begin
				if (adv) begin
					dv_div_s[j][k] <= div_prev;
					if (trial >= {1'b0, div_prev}) begin
						dv_rem_s[j][k] <= diff[CHARGE_BITS-1:0];
						dv_quo_s[j][k] <= quo_prev | (QUO_BITS'(1) << (QUO_BITS - 1 - k));
					end else begin
						dv_rem_s[j][k] <= trial[CHARGE_BITS-1:0];
						dv_quo_s[j][k] <= quo_prev;
					end
				end
			end
		end

		// Digit-by-digit square root of the quotient, one root bit per stage.
		for (genvar m = 0; m < ROOT_BITS; m++) begin : g_sqrt
			logic [2*ROOT_BITS-1:0] rad_prev;
			logic [REM_BITS-1:0]    rem_prev;
			logic [ROOT_BITS-1:0]   root_prev;
			logic [REM_BITS-1:0]    acc;
			logic [REM_BITS-1:0]    trial;

			if (m == 0) begin : g_first
				assign rad_prev  = (2 * ROOT_BITS)'(dv_quo_s[j][QUO_BITS-1]);
				assign rem_prev  = '0;
				assign root_prev = '0;
			end else begin : g_next
				assign rad_prev  = sq_rad_s[j][m-1];
				assign rem_prev  = sq_rem_s[j][m-1];
				assign root_prev = sq_root_s[j][m-1];
			end

			assign acc   = {rem_prev[REM_BITS-3:0],
				rad_prev[2*(ROOT_BITS-1-m)+1 -: 2]};
			assign trial = {root_prev, 2'b01};

			always_ff @(posedge clk) begin
				if (adv) begin
					sq_rad_s[j][m] <= rad_prev;
					if (acc >= trial) begin
						sq_rem_s[j][m]  <= acc - trial;
						sq_root_s[j][m] <= {root_prev[ROOT_BITS-2:0], 1'b1};
					end else begin
						sq_rem_s[j][m]  <= acc;
						sq_root_s[j][m] <= {root_prev[ROOT_BITS-2:0], 1'b0};
					end
				end
			end
		end
	end

	// Round each root to Q0.24 and form the signed walk term.
	logic [ROOT_BITS:0]           rnd [LANES];
	logic signed [W_BITS-1:0]     inv_term [LANES];

	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			rnd[j]      = {1'b0, sq_root_s[j][ROOT_BITS-1]} + (ROOT_BITS + 1)'(1);
			inv_term[j] = signed'(W_BITS'(rnd[j][ROOT_BITS:1]));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s <= inv_term[0] + inv_term[1] - inv_term[2] - inv_term[3];
		end
	end

	// Coefficient times walk term, Q19.40.
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s <= PROD_BITS'(signed'(coef_q)) * PROD_BITS'(w_s);
		end
	end

	// Round to picoseconds, subtract and clamp into the output register.
	logic signed [PROD_BITS-1:0]  prod_rnd;
	logic signed [CORR_BITS-1:0]  corr;
	logic signed [DIFF_BITS-1:0]  diff_t;

	always_comb begin
		prod_rnd = prod_s + (PROD_BITS'(1) <<< (ROUND_SHIFT - 1));
		corr     = prod_rnd[PROD_BITS-1:ROUND_SHIFT];
		diff_t   = DIFF_BITS'(signed'(tim_s[MUL_STG])) - DIFF_BITS'(corr);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_inv_s <= inv_s[MUL_STG];
			if (inv_s[MUL_STG]) begin
				res_s     <= tim_s[MUL_STG];
				res_sat_s <= 1'b0;
			end else if (diff_t > T_MAX) begin
				res_s     <= T_MAX[TIME_BITS-1:0];
				res_sat_s <= 1'b1;
			end else if (diff_t < T_MIN) begin
				res_s     <= T_MIN[TIME_BITS-1:0];
				res_sat_s <= 1'b1;
			end else begin
				res_s     <= diff_t[TIME_BITS-1:0];
				res_sat_s <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid              = vld_s[OUT_STG];
	assign m_axis_tdata               = OUT_W'(res_s);
	assign m_axis_tuser[USER_INVALID] = res_inv_s;
	assign m_axis_tuser[USER_SAT]     = res_sat_s;

	// An invalid event never reports saturation.
	a_inv_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[USER_INVALID] |-> !m_axis_tuser[USER_SAT])
		else $error("saturation flagged on an invalid-charge event");

	// Input is refused exactly while a held result blocks the pipeline.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow the output stall");

	// A coefficient write takes effect on the next cycle.
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> coef_q == $past(cfg_data))
		else $error("coefficient write lost");

	// A saturated result sits at one of the range limits.
	a_sat_lim: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[USER_SAT] |->
			(res_s == T_MAX[TIME_BITS-1:0]) || (res_s == T_MIN[TIME_BITS-1:0]))
		else $error("saturated result is not a range limit");

endmodule

FILE: dv/time_walk_correction_tb.sv
`timescale 1ns / 100ps

module time_walk_correction_tb;
	import twc_pkg::*;

	localparam int TW = 24;
	localparam int QW = 16;
	localparam int IN_W = ((TW + 4 * QW + 7) / 8) * 8;
	localparam int OUT_W = ((TW + 7) / 8) * 8;
	localparam int LATENCY = 80;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_EVENTS = 950;

	typedef struct packed {
		logic signed [TW-1:0] tdiff;
		logic [QW-1:0] qa1;
		logic [QW-1:0] qb1;
		logic [QW-1:0] qa2;
		logic [QW-1:0] qb2;
	} event_t;

	typedef struct packed {
		logic signed [TW-1:0] corrected;
		logic invalid;
		logic sat;
	} corr_t;

	// One directed row; has_expect marks a hand-typed expectation.
	typedef struct packed {
		event_t ev;
		logic has_expect;
		corr_t exp_res;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic cfg_valid;
	logic cfg_ready;
	logic [COEF_BITS-1:0] cfg_data;

	logic signed [31:0] coef_model;
	corr_t expected_q[$];
	int fail_count;
	int event_count;
	int result_count;
	int cfg_count;
	int invalid_count;
	int sat_count;
	int idle_cycles;
	bit stream_done;

	time_walk_correction dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Rounded 2^24/sqrt(q) by a bitwise integer square root of floor(2^50/q).
	function automatic longint unsigned inv_root(input logic [QW-1:0] q);
		longint unsigned n;
		longint unsigned root;
		longint unsigned b;
		n = (64'd1 << 50) / q;
		root = 0;
		b = 64'd1 << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= root + b) begin
				n = n - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return (root + 1) >> 1;
	endfunction

	// Walk-corrected time for one event under the current coefficient.
	function automatic corr_t walk_correct(input event_t ev);
		corr_t r;
		longint w;
		longint prod;
		longint corr;
		longint t;
		r.invalid = (ev.qa1 == 0) || (ev.qb1 == 0) || (ev.qa2 == 0) || (ev.qb2 == 0);
		r.sat = 1'b0;
		r.corrected = ev.tdiff;
		if (!r.invalid) begin
			w = longint'(inv_root(ev.qa1)) + longint'(inv_root(ev.qb1))
				- longint'(inv_root(ev.qa2)) - longint'(inv_root(ev.qb2));
			prod = longint'(coef_model) * w;
			corr = (prod + (64'sd1 <<< 39)) >>> 40;
			t = longint'(ev.tdiff) - corr;
			if (t > 64'sd8388607) begin
				t = 64'sd8388607;
				r.sat = 1'b1;
			end else if (t < -64'sd8388608) begin
				t = -64'sd8388608;
				r.sat = 1'b1;
			end
			r.corrected = t[TW-1:0];
		end
		return r;
	endfunction

	// The time sits in the lowest bits of tdata, then the four charges in order.
	function automatic event_t unpack_event(input logic [IN_W-1:0] data);
		event_t ev;
		ev.tdiff = data[TW-1:0];
		ev.qa1 = data[TW +: QW];
		ev.qb1 = data[TW + QW +: QW];
		ev.qa2 = data[TW + 2 * QW +: QW];
		ev.qb2 = data[TW + 3 * QW +: QW];
		return ev;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
		fail_count++;
	endtask

	// Called at a falling edge; leaves tvalid high so beats can follow back to back.
	task automatic send_event(input event_t ev);
		int gap;
		gap = $urandom_range(0, 11);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata <= {ev.qb2, ev.qa2, ev.qb1, ev.qa1, ev.tdiff};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Waits for the pipeline to drain, then writes a new coefficient.
	task automatic write_coef(input logic signed [31:0] value);
		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		coef_model = value;
		cfg_count++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [QW-1:0] rand_charge();
		case ($urandom_range(0, 9))
			0: return QW'(1);
			1: return QW'(16'hFFFF);
			2: return QW'($urandom_range(1, 255));
			default: return QW'($urandom_range(1, 65535));
		endcase
	endfunction

	function automatic event_t rand_event();
		event_t ev;
		ev.tdiff = TW'($urandom);
		if ($urandom_range(0, 15) == 0)
			ev.tdiff = ($urandom_range(0, 1) != 0) ? 24'sh7FFFFF : 24'sh800000;
		ev.qa1 = rand_charge();
		ev.qb1 = rand_charge();
		ev.qa2 = rand_charge();
		ev.qb2 = rand_charge();
		// A few events carry a zero charge.
		if ($urandom_range(0, 19) == 0)
			case ($urandom_range(0, 3))
				0: ev.qa1 = '0;
				1: ev.qb1 = '0;
				2: ev.qa2 = '0;
				default: ev.qb2 = '0;
			endcase
		return ev;
	endfunction

	// Record the expectation of every accepted input beat.
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			expected_q.insert(expected_q.size(),
				walk_correct(unpack_event(s_axis_tdata)));
			event_count++;
		end
	end

	// Check output beats against the oldest expectation.
	always @(posedge clk) begin
		corr_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			result_count++;
			if (expected_q.size() == 0) begin
				report("unexpected beat", m_axis_tdata, 0);
			end else begin
				want = expected_q.pop_front();
				if (m_axis_tdata[TW-1:0] !== want.corrected)
					report("corrected_time", $signed(m_axis_tdata[TW-1:0]),
						want.corrected);
				if (m_axis_tuser[USER_INVALID] !== want.invalid)
					report("charge_invalid", m_axis_tuser[USER_INVALID], want.invalid);
				if (m_axis_tuser[USER_SAT] !== want.sat)
					report("saturated", m_axis_tuser[USER_SAT], want.sat);
				invalid_count += want.invalid;
				sat_count += want.sat;
			end
		end
	end

	// Receiver stalls drawn per beat, with stall-free stretches.
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = ($urandom_range(0, 199) < 60) ? 0 : $urandom_range(0, 11);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid)
				@(posedge clk);
		end
	end

	// Watchdog on cycles without any accepted beat.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready) || stream_done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog expired after %0d idle cycles", idle_cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		dir_row_t rows[$];
		event_t ev;
		corr_t got_exp;
		int wait_count;
		logic signed [31:0] coefs[6];
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		fail_count = 0;
		event_count = 0;
		result_count = 0;
		cfg_count = 0;
		invalid_count = 0;
		sat_count = 0;
		idle_cycles = 0;
		stream_done = 1'b0;
		coef_model = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// After reset the coefficient is zero, so times pass through.
		rows.insert(rows.size(), '{'{24'sh7FFFFF, 16'd1, 16'hFFFF, 16'd1, 16'hFFFF}, 1'b1,
			'{24'sh7FFFFF, 1'b0, 1'b0}});
		rows.insert(rows.size(), '{'{24'sh800000, 16'd1, 16'd1, 16'hFFFF, 16'hFFFF}, 1'b1,
			'{24'sh800000, 1'b0, 1'b0}});
		rows.insert(rows.size(), '{'{24'sh123456, 16'd0, 16'd5, 16'd5, 16'd5}, 1'b1,
			'{24'sh123456, 1'b1, 1'b0}});
		rows.insert(rows.size(), '{'{24'sh000000, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
			'{24'sh000000, 1'b1, 1'b0}});
		foreach (rows[i]) begin
			got_exp = walk_correct(rows[i].ev);
			if (rows[i].has_expect && got_exp !== rows[i].exp_res)
				report("directed table", got_exp.corrected, rows[i].exp_res.corrected);
			send_event(rows[i].ev);
		end

		// Largest positive coefficient: extremes, zero charges on the last three lanes, saturation.
		write_coef(32'sh7FFFFFFF);
		rows.delete();
		rows.insert(rows.size(), '{'{24'sh000000, 16'd1, 16'd1, 16'hFFFF, 16'hFFFF}, 1'b0, '0});
		rows.insert(rows.size(), '{'{24'sh800000, 16'd1, 16'd1, 16'hFFFF, 16'hFFFF}, 1'b0, '0});
		rows.insert(rows.size(), '{'{24'sh7FFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 16'd1}, 1'b0, '0});
		rows.insert(rows.size(), '{'{24'sh7FFFFF, 16'd7, 16'd7, 16'd7, 16'd7}, 1'b0, '0});
		rows.insert(rows.size(), '{'{24'sh7FFFFF, 16'd1, 16'd0, 16'd1, 16'd1}, 1'b1,
			'{24'sh7FFFFF, 1'b1, 1'b0}});
		rows.insert(rows.size(), '{'{24'sh800000, 16'd1, 16'd1, 16'd0, 16'd1}, 1'b1,
			'{24'sh800000, 1'b1, 1'b0}});
		rows.insert(rows.size(), '{'{24'sh000001, 16'd1, 16'd1, 16'd1, 16'd0}, 1'b1,
			'{24'sh000001, 1'b1, 1'b0}});
		rows.insert(rows.size(), '{'{24'shFFFFFF, 16'd2, 16'd3, 16'd4, 16'd5}, 1'b0, '0});
		foreach (rows[i]) begin
			got_exp = walk_correct(rows[i].ev);
			if (rows[i].has_expect && got_exp !== rows[i].exp_res)
				report("directed table", got_exp.corrected, rows[i].exp_res.corrected);
			send_event(rows[i].ev);
		end

		// Most negative coefficient and a unit coefficient, whose correction rounds to zero.
		write_coef(32'sh80000000);
		send_event('{24'sh000000, 16'd1, 16'd1, 16'hFFFF, 16'hFFFF});
		send_event('{24'sh7FFFFF, 16'd1, 16'd1, 16'hFFFF, 16'hFFFF});
		send_event('{24'sh5A5A5A, 16'hAAAA, 16'h5555, 16'h8000, 16'h0001});
		write_coef(32'sh00000001);
		send_event('{24'sh000000, 16'd1, 16'd1, 16'hFFFF, 16'hFFFF});
		send_event('{24'sh000000, 16'd4, 16'd4, 16'd1, 16'd9});
		send_event('{24'sh000000, 16'hFFFF, 16'd3, 16'd1, 16'd2});

		// Random phases over a spread of coefficients.
		coefs[0] = 32'sh00010000;
		coefs[1] = -32'sh00280000;
		coefs[2] = 32'sh7FFFFFFF;
		coefs[3] = 32'sh80000000;
		coefs[4] = 0;
		coefs[5] = 32'sh00000001;
		for (int p = 0; p < 8; p++) begin
			if (p < 6)
				write_coef(coefs[p]);
			else
				write_coef($urandom);
			for (int i = 0; i < RANDOM_EVENTS / 8; i++) begin
				ev = rand_event();
				send_event(ev);
			end
		end

		s_axis_tvalid <= 1'b0;
		stream_done = 1'b1;
		wait_count = 0;
		while (expected_q.size() != 0 && wait_count < 20 * WATCHDOG_LIMIT) begin
			@(negedge clk);
			wait_count++;
		end
		repeat (LATENCY + 10) @(negedge clk);
		if (expected_q.size() != 0)
			report("results missing", expected_q.size(), 0);

		$display("Covered %0d events, %0d results, %0d coefficient writes.",
			event_count, result_count, cfg_count);
		$display("Of those, %0d had a zero charge and %0d saturated.",
			invalid_count, sat_count);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
